// ===== sv/pclp_pkg.sv =====
`timescale 1ns / 1ps
// Package for the PI current loop with PWM output: register indexes, reset gains,
// fixed-point constants and the sequencer state type. No dependencies.
package pclp_pkg;

  // Default number of motor channels.
  localparam int CHANNELS_DEFAULT = 2;

  // Configuration port geometry.
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PROP_GAIN     = 2'd0,
    REG_INTEG_GAIN    = 2'd1,
    REG_SPEED_FF_GAIN = 2'd2
  } reg_index_t;

  // Reset values of the gains, unsigned Q8.24.
  localparam logic [CFG_DATA_W-1:0] PROP_GAIN_RESET     = 32'd1678;
  localparam logic [CFG_DATA_W-1:0] INTEG_GAIN_RESET    = 32'd106149;
  localparam logic [CFG_DATA_W-1:0] SPEED_FF_GAIN_RESET = 32'd56623;

  // Fixed-point geometry and widths of the shared multiplier.
  localparam int FRAC_INT   = 24;
  localparam int PORT_SHIFT = 12;
  localparam int MUL_A_W    = 17;
  localparam int MUL_B_W    = 33;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int INTEG_W    = 27;
  localparam int MAG_W      = 25;

  // Duty scaling and limits.
  localparam logic signed [MUL_A_W-1:0] DUTY_SCALE = 17'sd1000;
  localparam logic [9:0] DUTY_MAX = 10'd990;
  localparam logic [9:0] DUTY_MIN = 10'd1;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_I,
    ST_MUL_P,
    ST_MUL_F,
    ST_SUM,
    ST_LIM,
    ST_DUTY,
    ST_OUT
  } state_t;

endpackage

// ===== sv/pi_current_loop_pwm.sv =====
`timescale 1ns / 1ps
// Per-channel PI current controller with speed feedforward and PWM duty output.
// Depends on pclp_pkg for constants, register indexes and the state type.
//
// Usage: the input channel carries one control tick (channel, target_current,
// measured_current, speed) under in_valid / in_stall; the output channel carries
// one result (out_channel, direction, duty, drive_value, integ_clamped) under
// out_valid / out_stall. An item is taken at an edge where valid is high and
// stall is low. Gains are written through cfg_we / cfg_index / cfg_data; the user
// must do so only while idle, as the block itself does not enforce it.
//
// Each item runs through a small sequencer around one shared 17x33 signed
// multiplier, which computes the integral, proportional and feedforward
// products and finally the duty scaling. A new item is taken only in the idle
// state that follows loading the previous result into the output register, so
// the block does not take an item before it is through with the last one. The
// output register keeps the result while out_stall is high; if a second result
// is ready before the first is taken, the sequencer waits in its last step.
// Reset empties the output, restores the default gains and clears all integrators.
module pi_current_loop_pwm #(
  parameter int CHANNELS = pclp_pkg::CHANNELS_DEFAULT
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Configuration port.
  input  logic                                 cfg_we,
  input  logic [pclp_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [pclp_pkg::CFG_DATA_W-1:0]      cfg_data,
  // Input channel.
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 channel,
  input  logic signed [15:0]                   target_current,
  input  logic signed [15:0]                   measured_current,
  input  logic signed [15:0]                   speed,
  // Output channel.
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_channel,
  output logic                                 direction,
  output logic [9:0]                           duty,
  output logic signed [13:0]                   drive_value,
  output logic                                 integ_clamped
);
  import pclp_pkg::*;

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic signed [37:0] ONE_38 = 38'sd16777216;
  localparam logic signed [49:0] ONE_50 = 50'sd16777216;

  // Gain registers.
  logic [CFG_DATA_W-1:0] prop_gain;
  logic [CFG_DATA_W-1:0] integ_gain;
  logic [CFG_DATA_W-1:0] speed_ff_gain;

  // Sequencer state.
  state_t state;
  state_t state_next;

  // Per-channel integrators, signed Q.24.
  logic signed [INTEG_W-1:0] integrator [CHANNELS];

  // Item working registers.
  logic [CH_W-1:0]           ch_q;
  logic signed [16:0]        err_q;
  logic signed [15:0]        spd_q;
  logic signed [PROD_W-1:0]  prod_q;
  logic signed [INTEG_W-1:0] integ_q;
  logic                      hit_q;
  logic signed [PROD_W-1:0]  acc_q;
  logic                      dir_q;
  logic [MAG_W-1:0]          mag_q;
  logic signed [13:0]        drive_q;

  // Shared multiplier operands and control.
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_res;
  logic                      prod_load;

  // Combinational datapath values.
  logic                      in_take;
  logic                      out_free;
  logic signed [37:0]        integ_sum;
  logic signed [INTEG_W-1:0] integ_new;
  logic                      integ_hit;
  logic signed [25:0]        lim;
  logic [9:0]                duty_raw;
  logic [9:0]                duty_fix;

  assign mul_res  = mul_a * mul_b;
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  // Configuration writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain     <= PROP_GAIN_RESET;
      integ_gain    <= INTEG_GAIN_RESET;
      speed_ff_gain <= SPEED_FF_GAIN_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PROP_GAIN:     prop_gain     <= cfg_data;
        REG_INTEG_GAIN:    integ_gain    <= cfg_data;
        REG_SPEED_FF_GAIN: speed_ff_gain <= cfg_data;
        default: ;
      endcase
    end
  end

  // Next-state logic of the sequencer.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:  if (in_valid) state_next = ST_MUL_I;
      ST_MUL_I: state_next = ST_MUL_P;
      ST_MUL_P: state_next = ST_MUL_F;
      ST_MUL_F: state_next = ST_SUM;
      ST_SUM:   state_next = ST_LIM;
      ST_LIM:   state_next = ST_DUTY;
      ST_DUTY:  state_next = ST_OUT;
      ST_OUT:   if (out_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer outputs: input stall and multiplier operand selection.
  always_comb begin
    in_stall  = 1'b1;
    mul_a     = '0;
    mul_b     = '0;
    prod_load = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
      end
      ST_MUL_I: begin
        mul_a     = err_q;
        mul_b     = {1'b0, integ_gain};
        prod_load = 1'b1;
      end
      ST_MUL_P: begin
        mul_a     = err_q;
        mul_b     = {1'b0, prop_gain};
        prod_load = 1'b1;
      end
      ST_MUL_F: begin
        mul_a     = {spd_q[15], spd_q};
        mul_b     = {1'b0, speed_ff_gain};
        prod_load = 1'b1;
      end
      ST_DUTY: begin
        mul_a     = DUTY_SCALE;
        mul_b     = {{(MUL_B_W-MAG_W){1'b0}}, mag_q};
        prod_load = 1'b1;
      end
      default: ;
    endcase
  end

  // Integrator update: add the integral increment and clamp to plus or minus one.
  always_comb begin
    integ_sum = {{(38-INTEG_W){integrator[ch_q][INTEG_W-1]}}, integrator[ch_q]}
              + prod_q[49:12];
    integ_hit = 1'b0;
    integ_new = integ_sum[INTEG_W-1:0];
    if (integ_sum >= ONE_38) begin
      integ_new = ONE_38[INTEG_W-1:0];
      integ_hit = 1'b1;
    end else if (integ_sum <= -ONE_38) begin
      integ_new = 27'(-ONE_38);
      integ_hit = 1'b1;
    end
  end

  // Drive clamp to plus or minus one.
  always_comb begin
    if (acc_q > ONE_50) begin
      lim = ONE_50[25:0];
    end else if (acc_q < -ONE_50) begin
      lim = 26'(-ONE_50);
    end else begin
      lim = acc_q[25:0];
    end
  end

  // Duty from the scaled magnitude, forced into its legal range.
  always_comb begin
    duty_raw = prod_q[FRAC_INT+9:FRAC_INT];
    if (duty_raw < 10'd2) begin
      duty_fix = DUTY_MIN;
    end else if (duty_raw > DUTY_MAX) begin
      duty_fix = DUTY_MAX;
    end else begin
      duty_fix = duty_raw;
    end
  end

  // Item datapath registers.
  always_ff @(posedge clk) begin
    if (in_take) begin
      if (32'(channel) >= CHANNELS) begin
        ch_q <= CH_W'(CHANNELS - 1);
      end else begin
        ch_q <= CH_W'(channel);
      end
      err_q <= {target_current[15], target_current}
             - {measured_current[15], measured_current};
      spd_q <= speed;
    end
    if (prod_load) begin
      prod_q <= mul_res;
    end
    case (state)
      ST_MUL_P: begin
        integ_q <= integ_new;
        hit_q   <= integ_hit;
      end
      ST_MUL_F: begin
        acc_q <= {{(PROD_W-INTEG_W){integ_q[INTEG_W-1]}}, integ_q}
               + {{12{prod_q[49]}}, prod_q[49:12]};
      end
      ST_SUM: begin
        acc_q <= acc_q + prod_q;
      end
      ST_LIM: begin
        dir_q   <= !acc_q[49];
        mag_q   <= lim[25] ? MAG_W'(-lim) : lim[MAG_W-1:0];
        drive_q <= lim[25:12];
      end
      default: ;
    endcase
  end

  // Integrator store, cleared at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        integrator[i] <= '0;
      end
    end else if (state == ST_MUL_P) begin
      integrator[ch_q] <= integ_new;
    end
  end

  // Output register: loaded when empty or being taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      out_channel   <= ch_q[0];
      direction     <= dir_q;
      duty          <= duty_fix;
      drive_value   <= drive_q;
      integ_clamped <= hit_q;
    end
  end

endmodule

// ===== sv/pclp_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the PI current loop with PWM output, and its bind.
// Depends on the ports of pi_current_loop_pwm only.
module pclp_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic               direction,
  input logic [9:0]         duty,
  input logic signed [13:0] drive_value
);

  // A result waiting on a stalled receiver stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  // After an item is taken the block is busy on it.
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("item taken while the previous one is still at work");

  // Duty stays within its legal range.
  a_duty_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (duty >= 10'd1) && (duty <= 10'd990))
    else $error("duty out of range");

  // Drive stays within plus or minus one.
  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (drive_value >= -14'sd4096) && (drive_value <= 14'sd4096))
    else $error("drive value out of range");

  // Direction agrees with the sign of the drive.
  a_dir_sign: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (direction == (drive_value >= 14'sd0)))
    else $error("direction disagrees with drive sign");

endmodule

bind pi_current_loop_pwm pclp_checker u_pclp_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .direction   (direction),
  .duty        (duty),
  .drive_value (drive_value)
);
